FILE: hw/rtl/dwarf_encoded_pointer_decoder_assert.svh
// Assertion macros used by the port-level checker of the encoded pointer decoder.
`ifndef DWARF_ENCODED_POINTER_DECODER_ASSERT_SVH
`define DWARF_ENCODED_POINTER_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge of clk.
`define DEP_ASSERT_SAME(label, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge of clk.
`define DEP_ASSERT_NEXT(label, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/dep_pkg.sv
// Types and constants shared by the encoded pointer decoder and its checker.
package dep_pkg;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_UNSUPPORTED = 2'd1,
    STATUS_STRAY       = 2'd2
  } dep_status_t;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  localparam logic [7:0] ENC_OMIT = 8'hFF;

  localparam logic [3:0] FMT_ABS  = 4'h0;
  localparam logic [3:0] FMT_ULEB = 4'h1;
  localparam logic [3:0] FMT_U2   = 4'h2;
  localparam logic [3:0] FMT_U4   = 4'h3;
  localparam logic [3:0] FMT_U8   = 4'h4;
  localparam logic [3:0] FMT_SLEB = 4'h9;
  localparam logic [3:0] FMT_S2   = 4'hA;
  localparam logic [3:0] FMT_S4   = 4'hB;
  localparam logic [3:0] FMT_S8   = 4'hC;

  localparam logic [2:0] MODE_ABS   = 3'b000;
  localparam logic [2:0] MODE_PCREL = 3'b001;

  localparam logic [4:0] COUNT_MAX = 5'd16;

  typedef struct packed {
    logic        kind;
    logic [7:0]  encoding;
    logic [63:0] value_address;
    logic [7:0]  data_byte;
  } dep_req_t;

  typedef struct packed {
    logic [63:0] value;
    dep_status_t status;
    logic        needs_indirect;
    logic [4:0]  byte_count;
  } dep_res_t;

endpackage

FILE: hw/rtl/dwarf_encoded_pointer_decoder.sv
// Top level of the DWARF exception-table encoded pointer decoder.
//
// Requests arrive on in_valid/in_stall/in_data. A start request carries the
// encoding byte and the address of the value; data requests then bring the
// encoded bytes one at a time. Each request is decoded in the cycle it is
// accepted, so one request can be taken every clock cycle while in_stall is low.
// A result appears on out_valid/out_data in the cycle after the request that
// causes it (the byte that completes a value, an omit or unsupported encoding,
// or a stray data byte) if no stalled result holds the output register, and
// else waits in a one-entry skid stage. Requests that leave a value open give
// no result. A request is still taken while a result waits; in_stall rises only
// when the skid stage is full, and falls in the cycle after the receiver takes
// a result. Indirect encodings are flagged in needs_indirect, not dereferenced.
// A synchronous reset empties both result stages and closes any open value.
module dwarf_encoded_pointer_decoder #(
  parameter int POINTER_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  dep_pkg::dep_req_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output dep_pkg::dep_res_t out_data
);
  import dep_pkg::*;

  localparam logic [3:0] PtrBytes = 4'(POINTER_BYTES);

  logic [63:0] accumulator, accumulator_next;
  logic [6:0]  bit_shift, bit_shift_next;
  logic [7:0]  held_encoding, held_encoding_next;
  logic [63:0] base_address, base_address_next;
  logic        value_open, value_open_next;
  logic [4:0]  bytes_seen, bytes_seen_next;
  logic        skid_valid;
  dep_res_t    skid_data;

  logic        in_req;
  logic        out_take;
  logic        res_fire;
  dep_res_t    res_word;
  logic [3:0]  start_width;
  logic        start_ok;
  logic [3:0]  held_fmt;
  logic [3:0]  held_width;
  logic [4:0]  seen_inc;
  logic [63:0] fixed_acc;
  logic [63:0] fixed_done_acc;
  logic        fixed_done;
  logic        leb_in_range;
  logic [63:0] leb_acc;
  logic [6:0]  leb_shift;
  logic [63:0] leb_done_acc;
  logic [63:0] done_acc;
  logic [63:0] base_sel;

  function automatic logic [3:0] fixed_width(input logic [3:0] fmt);
    logic [3:0] w;
    unique case (fmt) inside
      FMT_ABS:        w = PtrBytes;
      FMT_U2, FMT_S2: w = 4'd2;
      FMT_U4, FMT_S4: w = 4'd4;
      FMT_U8, FMT_S8: w = 4'd8;
      default:        w = 4'd0;
    endcase
    return w;
  endfunction

  assign in_stall = skid_valid;
  assign in_req   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  assign start_width = fixed_width(in_data.encoding[3:0]);
  assign start_ok    = (start_width != 4'd0 || in_data.encoding[3:0] == FMT_ULEB ||
                        in_data.encoding[3:0] == FMT_SLEB) &&
                       (in_data.encoding[6:4] == MODE_ABS ||
                        in_data.encoding[6:4] == MODE_PCREL);

  assign held_fmt   = held_encoding[3:0];
  assign held_width = fixed_width(held_fmt);
  assign seen_inc   = (bytes_seen < COUNT_MAX) ? bytes_seen + 5'd1 : bytes_seen;

  assign fixed_acc  = accumulator |
                      ({56'd0, in_data.data_byte} << {bytes_seen[2:0], 3'b000});
  assign fixed_done = {1'b0, held_width} <= seen_inc;

  always_comb begin
    fixed_done_acc = fixed_acc;
    if (held_fmt == FMT_S2 && fixed_acc[15]) begin
      fixed_done_acc = fixed_acc | {{48{1'b1}}, 16'd0};
    end else if (held_fmt == FMT_S4 && fixed_acc[31]) begin
      fixed_done_acc = fixed_acc | {{32{1'b1}}, 32'd0};
    end
  end

  assign leb_in_range = !bit_shift[6];
  assign leb_acc      = leb_in_range ?
                        accumulator | ({57'd0, in_data.data_byte[6:0]} << bit_shift[5:0]) :
                        accumulator;
  assign leb_shift    = leb_in_range ? bit_shift + 7'd7 : bit_shift;

  always_comb begin
    leb_done_acc = leb_acc;
    if (held_fmt == FMT_SLEB && in_data.data_byte[6] && !leb_shift[6]) begin
      leb_done_acc = leb_acc | ({64{1'b1}} << leb_shift[5:0]);
    end
  end

  assign done_acc = (held_width != 4'd0) ? fixed_done_acc : leb_done_acc;
  assign base_sel = (held_encoding[6:4] == MODE_PCREL) ? base_address : 64'd0;

  always_comb begin
    accumulator_next   = accumulator;
    bit_shift_next     = bit_shift;
    held_encoding_next = held_encoding;
    base_address_next  = base_address;
    value_open_next    = value_open;
    bytes_seen_next    = bytes_seen;
    res_fire           = 1'b0;
    res_word.value          = 64'd0;
    res_word.status         = STATUS_OK;
    res_word.needs_indirect = 1'b0;
    res_word.byte_count     = 5'd0;
    if (in_req) begin
      if (in_data.kind == KIND_START) begin
        held_encoding_next = in_data.encoding;
        base_address_next  = in_data.value_address;
        accumulator_next   = 64'd0;
        bit_shift_next     = 7'd0;
        bytes_seen_next    = 5'd0;
        value_open_next    = 1'b0;
        if (in_data.encoding == ENC_OMIT) begin
          res_fire = 1'b1;
        end else if (!start_ok) begin
          res_fire        = 1'b1;
          res_word.status = STATUS_UNSUPPORTED;
        end else begin
          value_open_next = 1'b1;
        end
      end else if (!value_open) begin
        res_fire        = 1'b1;
        res_word.status = STATUS_STRAY;
      end else begin
        bytes_seen_next = seen_inc;
        if (held_width != 4'd0) begin
          accumulator_next = fixed_acc;
          res_fire         = fixed_done;
        end else begin
          accumulator_next = leb_acc;
          bit_shift_next   = leb_shift;
          res_fire         = !in_data.data_byte[7];
        end
        if (res_fire) begin
          value_open_next         = 1'b0;
          res_word.value          = done_acc + base_sel;
          res_word.needs_indirect = held_encoding[7];
          res_word.byte_count     = seen_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator   <= 64'd0;
      bit_shift     <= 7'd0;
      held_encoding <= 8'd0;
      base_address  <= 64'd0;
      value_open    <= 1'b0;
      bytes_seen    <= 5'd0;
      out_valid     <= 1'b0;
      skid_valid    <= 1'b0;
    end else begin
      accumulator   <= accumulator_next;
      bit_shift     <= bit_shift_next;
      held_encoding <= held_encoding_next;
      base_address  <= base_address_next;
      value_open    <= value_open_next;
      bytes_seen    <= bytes_seen_next;
      if (skid_valid) begin
        if (out_take) begin
          out_data   <= skid_data;
          skid_valid <= 1'b0;
        end
      end else if (res_fire) begin
        if (!out_valid || out_take) begin
          out_data  <= res_word;
          out_valid <= 1'b1;
        end else begin
          skid_data  <= res_word;
          skid_valid <= 1'b1;
        end
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/dep_checker.sv
// Port-level checker for the encoded pointer decoder, bound to its top level.
`include "dwarf_encoded_pointer_decoder_assert.svh"

module dep_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input dep_pkg::dep_req_t in_data,
  input logic              out_valid,
  input logic              out_stall,
  input dep_pkg::dep_res_t out_data
);
  import dep_pkg::*;

  `DEP_ASSERT_NEXT(a_reset_empty, 1'b0, rst, !out_valid && !in_stall, "Reset left a result pending.")

  `DEP_ASSERT_NEXT(a_out_hold, rst, out_valid && out_stall, out_valid && $stable(out_data), "Stalled result changed.")

  `DEP_ASSERT_SAME(a_error_clean, rst, out_valid && out_data.status != STATUS_OK, out_data.value == 64'd0 && !out_data.needs_indirect && out_data.byte_count == 5'd0, "Error result carries data.")

  `DEP_ASSERT_NEXT(a_omit_next, rst, in_valid && !in_stall && in_data.kind == KIND_START && in_data.encoding == ENC_OMIT && (!out_valid || !out_stall), out_valid && out_data.status == STATUS_OK && out_data.value == 64'd0 && out_data.byte_count == 5'd0, "Omit request gave no zero result.")

endmodule

bind dwarf_encoded_pointer_decoder dep_checker u_dep_checker (.*);

FILE: tb/sv/dep_result_checker.sv
// Watches both channels of the encoded pointer decoder, predicts each result and compares it.
module dep_result_checker #(
  parameter int POINTER_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  dep_pkg::dep_req_t in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  dep_pkg::dep_res_t out_data,
  output int                failures,
  output int                pending
);
  import dep_pkg::*;

  logic [63:0] acc;
  logic [63:0] base;
  logic [6:0]  shift;
  logic [7:0]  held_enc;
  logic        is_open;
  logic [4:0]  seen;
  dep_res_t    expected_results[$];

  function automatic int fmt_width(input logic [3:0] fmt);
    case (fmt) inside
      FMT_ABS: return POINTER_BYTES;
      FMT_U2, FMT_S2: return 2;
      FMT_U4, FMT_S4: return 4;
      FMT_U8, FMT_S8: return 8;
      default: return 0;
    endcase
  endfunction

  function automatic dep_res_t make_result(input logic [63:0] v, input dep_status_t st,
                                           input logic ind, input logic [4:0] cnt);
    dep_res_t r;
    r.value = v;
    r.status = st;
    r.needs_indirect = ind;
    r.byte_count = cnt;
    return r;
  endfunction

  task automatic close_value();
    logic [63:0] v;
    v = acc;
    if (held_enc[6:4] == MODE_PCREL) begin
      v = v + base;
    end
    expected_results.push_back(make_result(v, STATUS_OK, held_enc[7], seen));
    is_open = 1'b0;
  endtask

  task automatic decode_request(input dep_req_t rq);
    logic [3:0] fmt;
    logic [2:0] mode;
    logic [7:0] b;
    int         w;
    int         sh;
    if (rq.kind == KIND_START) begin
      held_enc = rq.encoding;
      base = rq.value_address;
      acc = '0;
      shift = '0;
      seen = '0;
      is_open = 1'b0;
      fmt = rq.encoding[3:0];
      mode = rq.encoding[6:4];
      if (rq.encoding == ENC_OMIT) begin
        expected_results.push_back(make_result('0, STATUS_OK, 1'b0, '0));
      end else if ((fmt_width(fmt) == 0 && fmt != FMT_ULEB && fmt != FMT_SLEB) ||
                   (mode != MODE_ABS && mode != MODE_PCREL)) begin
        expected_results.push_back(make_result('0, STATUS_UNSUPPORTED, 1'b0, '0));
      end else begin
        is_open = 1'b1;
      end
    end else if (!is_open) begin
      expected_results.push_back(make_result('0, STATUS_STRAY, 1'b0, '0));
    end else begin
      b = rq.data_byte;
      fmt = held_enc[3:0];
      w = fmt_width(fmt);
      if (seen < COUNT_MAX) begin
        seen = seen + 5'd1;
      end
      if (w != 0) begin
        sh = 8 * (int'(seen) - 1);
        acc = acc | (64'(b) << sh);
        if (int'(seen) >= w) begin
          if ((fmt == FMT_S2 || fmt == FMT_S4) && acc[8 * w - 1]) begin
            acc = acc | (~64'd0 << (8 * w));
          end
          close_value();
        end
      end else begin
        if (shift < 7'd64) begin
          acc = acc | (64'(b[6:0]) << shift);
          shift = shift + 7'd7;
        end
        if (!b[7]) begin
          if (fmt == FMT_SLEB && b[6] && shift < 7'd64) begin
            acc = acc | (~64'd0 << shift);
          end
          close_value();
        end
      end
    end
  endtask

  always @(posedge clk) begin
    dep_res_t want;
    if (rst) begin
      acc = '0;
      base = '0;
      shift = '0;
      held_enc = '0;
      is_open = 1'b0;
      seen = '0;
      expected_results.delete();
      failures = 0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_request(in_data);
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          failures++;
          if (failures <= 10) begin
            $display("unexpected result: value %h status %0d indirect %0b count %0d",
                     out_data.value, out_data.status, out_data.needs_indirect,
                     out_data.byte_count);
          end
        end else begin
          want = expected_results.pop_front();
          if (out_data.value !== want.value || out_data.status !== want.status ||
              out_data.needs_indirect !== want.needs_indirect ||
              out_data.byte_count !== want.byte_count) begin
            failures++;
            if (failures <= 10) begin
              $display("mismatch: expected value %h status %0d indirect %0b count %0d",
                       want.value, want.status, want.needs_indirect, want.byte_count);
              $display("          got      value %h status %0d indirect %0b count %0d",
                       out_data.value, out_data.status, out_data.needs_indirect,
                       out_data.byte_count);
            end
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

FILE: tb/sv/testbench.sv
// Top of the encoded pointer decoder testbench: stimulus, receiver stalls and the verdict.
module testbench;
  import dep_pkg::*;

  localparam int POINTER_BYTES = 8;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  dep_req_t in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  dep_res_t out_data;
  int       failures;
  int       pending;
  int       burst_left = 4;
  int       items_sent = 0;
  int       stall_phase = 0;
  int       stall_mode = 0;

  logic [3:0] supported_fmts[9] = '{FMT_ABS, FMT_ULEB, FMT_U2, FMT_U4, FMT_U8,
                                    FMT_SLEB, FMT_S2, FMT_S4, FMT_S8};

  dwarf_encoded_pointer_decoder #(
    .POINTER_BYTES(POINTER_BYTES)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  dep_result_checker #(
    .POINTER_BYTES(POINTER_BYTES)
  ) u_result_check (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .failures(failures),
    .pending(pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The receiver switches between free running, light, heavy and alternating stalls.
  always @(posedge clk) begin
    if (stall_phase == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_phase <= $urandom_range(20, 120);
    end else begin
      stall_phase <= stall_phase - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ~out_stall;
    endcase
  end

  function automatic int byte_width(input logic [3:0] fmt);
    case (fmt)
      FMT_ABS: return POINTER_BYTES;
      FMT_U2, FMT_S2: return 2;
      FMT_U4, FMT_S4: return 4;
      FMT_U8, FMT_S8: return 8;
      default: return 0;
    endcase
  endfunction

  task automatic send_request(input dep_req_t rq);
    int gap;
    in_data <= rq;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
  endtask

  task automatic send_start(input logic [7:0] enc, input logic [63:0] addr);
    dep_req_t rq;
    rq.kind = KIND_START;
    rq.encoding = enc;
    rq.value_address = addr;
    rq.data_byte = 8'($urandom);
    send_request(rq);
  endtask

  task automatic send_byte(input logic [7:0] b);
    dep_req_t rq;
    rq.kind = KIND_DATA;
    rq.encoding = 8'($urandom);
    rq.value_address = {$urandom, $urandom};
    rq.data_byte = b;
    send_request(rq);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Sends a start request followed by n bytes; LEB bytes carry continuation bits.
  task automatic send_value(input logic [7:0] enc, input int n, input logic complete);
    logic [7:0] b;
    logic       leb;
    leb = (enc[3:0] == FMT_ULEB || enc[3:0] == FMT_SLEB);
    send_start(enc, {$urandom, $urandom});
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom);
      if (leb) begin
        b[7] = !(complete && i == n - 1);
      end
      send_byte(b);
    end
  endtask

  initial begin
    logic [3:0] fmt;
    logic [2:0] mode;
    logic [7:0] enc;
    int         sel;
    int         n;
    int         r;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_byte(8'h5A);
    send_start(ENC_OMIT, '1);
    send_start(8'h05, '1);
    send_start(8'h24, '0);
    send_start(8'h92, '1);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_start(8'h0A, '0);
    send_byte(8'h00);
    send_byte(8'h80);
    send_start(8'h8B, 64'h8000_0000_0000_0000);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h80);
    send_start(8'h09, '0);
    send_byte(8'h40);
    send_start(8'h01, '1);
    send_byte(8'h80);
    send_byte(8'h00);
    send_start(8'h04, '0);
    send_byte(8'hA5);
    wait_for_results();

    items_sent = 0;
    while (items_sent < 600) begin
      sel = $urandom_range(0, 99);
      fmt = supported_fmts[$urandom_range(0, 8)];
      mode = $urandom_range(0, 1) ? MODE_PCREL : MODE_ABS;
      enc = {1'($urandom), mode, fmt};
      if (byte_width(fmt) != 0) begin
        n = byte_width(fmt);
      end else begin
        r = $urandom_range(0, 9);
        n = (r < 6) ? $urandom_range(1, 3) : (r < 9) ? $urandom_range(4, 10) :
            $urandom_range(11, 20);
      end
      if (sel < 70) begin
        send_value(enc, n, 1'b1);
      end else if (sel < 80) begin
        send_value(enc, $urandom_range(0, (n > 1) ? n - 1 : 0), 1'b0);
      end else if (sel < 88) begin
        send_byte(8'($urandom));
      end else if (sel < 95) begin
        send_value(8'($urandom), $urandom_range(0, 3), 1'b0);
      end else begin
        send_start(ENC_OMIT, {$urandom, $urandom});
      end
      if ($urandom_range(0, 99) == 0) begin
        wait_for_results();
      end
    end

    wait_for_results();
    repeat (8) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("testbench failed");
    $finish;
  end

endmodule

FILE: dwarf_encoded_pointer_decoder.f
+incdir+hw/rtl
hw/rtl/dep_pkg.sv
hw/rtl/dwarf_encoded_pointer_decoder.sv
hw/rtl/dep_checker.sv
tb/sv/dep_result_checker.sv
tb/sv/testbench.sv
